@@ rtl/core/port_number_allocator_assert.svh @@
// Assertion macros for the port number allocator.
`ifndef PORT_NUMBER_ALLOCATOR_ASSERT_SVH
`define PORT_NUMBER_ALLOCATOR_ASSERT_SVH

// Check that the consequent holds in the same cycle as the trigger.
`define PNA_ASSERT_SAME(label, trig, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (conseq)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the trigger.
`define PNA_ASSERT_NEXT(label, trig, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (conseq)) \
    else $error(msg);

`endif

@@ rtl/core/pna_pkg.sv @@
// Shared constants, codes and control structs of the port number allocator.
package pna_pkg;

  // Port number space and field widths
  localparam int PORT_BITS  = 16;
  localparam int PORT_W     = 16;
  localparam int DEPTH      = 1 << PORT_BITS;
  localparam int CNT_W      = PORT_BITS + 1;
  localparam int WIDE_W     = PORT_W + 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIDE_W-1:0] PORT_MAX = WIDE_W'(DEPTH - 1);

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0]  REG_RESERVED_A = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_RESERVED_B = 1'd1;
  localparam logic [CFG_DATA_W-1:0] RESERVED_A_RST = 16'd210;
  localparam logic [CFG_DATA_W-1:0] RESERVED_B_RST = 16'd800;

  // Request kinds
  localparam logic KIND_GET  = 1'b0;
  localparam logic KIND_FREE = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic pop;
    logic mark_rd;
    logic out_pop;
    logic out_fresh;
    logic free_chk;
    logic clear_step;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic stack_empty;
    logic out_busy;
    logic clear_done;
  } sts_t;

endpackage

@@ rtl/core/pna_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pna_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read; read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/pna_ctrl.sv @@
// Sequencing state machine of the port number allocator.
module pna_ctrl import pna_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_POP   = 3'd2;
  localparam logic [2:0] ST_FRESH = 3'd3;
  localparam logic [2:0] ST_FREE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Take a transaction only when idle
  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_kind == KIND_FREE) begin
            cmd.mark_rd = 1'b1;
            state_nxt   = ST_FREE;
          end else if (!sts.stack_empty) begin
            cmd.pop   = 1'b1;
            state_nxt = ST_POP;
          end else begin
            state_nxt = ST_FRESH;
          end
        end
      end
      ST_POP: begin
        if (!sts.out_busy) begin
          cmd.out_pop = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_FRESH: begin
        if (!sts.out_busy) begin
          cmd.out_fresh = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FREE: begin
        cmd.free_chk = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance state; reset starts the mark clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/pna_datapath.sv @@
// Free stack, used marks, fresh counter and result register of the allocator.
module pna_datapath import pna_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [PORT_W-1:0]     in_port,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [PORT_W-1:0]     out_granted_port,
  output logic                  out_error,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  logic [CFG_DATA_W-1:0] resv_a_r, resv_a_nxt;
  logic [CFG_DATA_W-1:0] resv_b_r, resv_b_nxt;
  logic [PORT_BITS-1:0]  counter_r, counter_nxt;
  logic [CNT_W-1:0]      free_count_r, free_count_nxt;
  logic [PORT_BITS-1:0]  clr_addr_r, clr_addr_nxt;
  logic [PORT_W-1:0]     port_r;
  logic                  port_ok_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [PORT_W-1:0]     granted_r;
  logic                  error_r;

  logic [CNT_W-1:0]      cnt_dec;
  logic [WIDE_W-1:0]     cand0, cand1, cand2;
  logic                  exhausted;
  logic                  push;

  logic                  stk_we;
  logic [PORT_BITS-1:0]  stk_q;
  logic                  mark_we;
  logic [PORT_BITS-1:0]  mark_waddr;
  logic                  mark_wdata;
  logic                  mark_q;

  // Fresh candidate: step past each reserved number, twice
  assign cand0 = WIDE_W'(counter_r) + WIDE_W'(1);
  assign cand1 = ((cand0 == WIDE_W'(resv_a_r)) || (cand0 == WIDE_W'(resv_b_r))) ?
                 cand0 + WIDE_W'(1) : cand0;
  assign cand2 = ((cand1 == WIDE_W'(resv_a_r)) || (cand1 == WIDE_W'(resv_b_r))) ?
                 cand1 + WIDE_W'(1) : cand1;
  assign exhausted = (cand2 > PORT_MAX);

  assign cnt_dec = free_count_r - CNT_W'(1);

  // Push a freed port only if it is in range, marked and the stack has room
  assign push   = cmd.free_chk && port_ok_r && mark_q && !free_count_r[CNT_W-1];
  assign stk_we = push;

  // Mark write select: clearing sweep, pop, fresh grant, free
  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = clr_addr_r;
    mark_wdata = 1'b0;
    if (cmd.clear_step) begin
      mark_we = 1'b1;
    end else if (cmd.out_pop) begin
      mark_we    = 1'b1;
      mark_waddr = stk_q;
      mark_wdata = 1'b1;
    end else if (cmd.out_fresh && !exhausted) begin
      mark_we    = 1'b1;
      mark_waddr = cand2[PORT_BITS-1:0];
      mark_wdata = 1'b1;
    end else if (push) begin
      mark_we    = 1'b1;
      mark_waddr = port_r[PORT_BITS-1:0];
    end
  end

  pna_ram #(.WIDTH(PORT_BITS), .DEPTH(DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (free_count_r[PORT_BITS-1:0]),
    .wdata (port_r[PORT_BITS-1:0]),
    .re    (cmd.pop),
    .raddr (cnt_dec[PORT_BITS-1:0]),
    .rdata (stk_q)
  );

  pna_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (cmd.mark_rd),
    .raddr (in_port[PORT_BITS-1:0]),
    .rdata (mark_q)
  );

  // Next values of the control registers
  always_comb begin
    resv_a_nxt     = resv_a_r;
    resv_b_nxt     = resv_b_r;
    counter_nxt    = counter_r;
    free_count_nxt = free_count_r;
    clr_addr_nxt   = clr_addr_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_RESERVED_A: resv_a_nxt = cfg_wdata;
        REG_RESERVED_B: resv_b_nxt = cfg_wdata;
        default: ;
      endcase
    end
    if (cmd.out_fresh && !exhausted) begin
      counter_nxt = cand2[PORT_BITS-1:0];
    end
    if (cmd.pop) begin
      free_count_nxt = cnt_dec;
    end else if (push) begin
      free_count_nxt = free_count_r + CNT_W'(1);
    end
    if (cmd.clear_step) begin
      clr_addr_nxt = clr_addr_r + PORT_BITS'(1);
    end
  end

  // Output register: load when empty or being taken, hold while stalled
  assign sts.out_busy = out_valid_r && out_stall;
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_pop || cmd.out_fresh) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resv_a_r     <= RESERVED_A_RST;
      resv_b_r     <= RESERVED_B_RST;
      counter_r    <= '0;
      free_count_r <= '0;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      resv_a_r     <= resv_a_nxt;
      resv_b_r     <= resv_b_nxt;
      counter_r    <= counter_nxt;
      free_count_r <= free_count_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      port_r    <= in_port;
      port_ok_r <= ({1'b0, in_port} <= PORT_MAX[PORT_W:0]);
    end
    if (cmd.out_pop) begin
      granted_r <= PORT_W'(stk_q);
      error_r   <= 1'b0;
    end else if (cmd.out_fresh) begin
      granted_r <= exhausted ? '0 : PORT_W'(cand2[PORT_BITS-1:0]);
      error_r   <= exhausted;
    end
  end

  assign sts.stack_empty = (free_count_r == '0);
  assign sts.clear_done  = &clr_addr_r;

  assign out_valid        = out_valid_r;
  assign out_granted_port = granted_r;
  assign out_error        = error_r;

endmodule

@@ rtl/core/port_number_allocator.sv @@
// Top level of the port number allocator.
// Input channel: in_valid/in_stall with in_kind (get or free) and in_port.
// A get yields one transaction on the out_ channel: out_granted_port, or
// out_error with a zero port once the fresh counter is used up. A free
// yields nothing; freeing a port that is not in use is dropped.
// Gets pop the most recently freed port first, then draw fresh numbers
// from 1 upwards, stepping past the two cfg_ reserved numbers.
// A transaction is accepted in the idle state, which issues the stack or
// mark RAM read where one is needed, and finishes in its own state, which
// uses the registered read data and, for a get, loads the result register.
// The result sits in an output register, so a new request is taken while
// it waits. A stalled result holds; a get that finishes under a stall
// waits in its result state, with in_stall high, until the register frees.
// After reset the used-mark RAM is swept clear, one entry a cycle, over all
// 2^PORT_BITS entries (65536); in_stall stays high meanwhile, while
// configuration writes are taken as ever.
module port_number_allocator import pna_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [PORT_W-1:0]     in_port,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PORT_W-1:0]     out_granted_port,
  output logic                  out_error,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  pna_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pna_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_port          (in_port),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_granted_port (out_granted_port),
    .out_error        (out_error),
    .cmd              (cmd),
    .sts              (sts)
  );

`include "port_number_allocator_assert.svh"

  `PNA_ASSERT_SAME(a_err_zero, out_valid && out_error, out_granted_port == '0, "error with port")
  `PNA_ASSERT_SAME(a_pop_nonempty, cmd.pop, !sts.stack_empty, "pop from empty stack")
  `PNA_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "back-to-back accept")
  `PNA_ASSERT_SAME(a_load_free, cmd.out_pop || cmd.out_fresh, !sts.out_busy, "result overwrite")

endmodule

@@ dv/tb_port_number_allocator.sv @@
// Self-checking testbench for the port number allocator with its own allocation predictor.
`timescale 1ns / 100ps

module tb_port_number_allocator import pna_pkg::*; ();

  localparam int TOP_PORT   = DEPTH - 1;
  localparam int IDLE_LIMIT = 200000;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic              err;
  } grant_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_kind;
  logic [PORT_W-1:0]     in_port;
  logic                  out_valid;
  logic                  out_stall;
  logic [PORT_W-1:0]     out_granted_port;
  logic                  out_error;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor state
  int                res_a;
  int                res_b;
  int                fresh_cnt;
  logic [PORT_W-1:0] free_stack[$];
  bit                port_used [0:DEPTH-1];
  logic [PORT_W-1:0] used_ports[$];
  logic [PORT_W-1:0] last_freed;
  grant_t            expected_grants[$];

  // Run bookkeeping
  int mismatch_count;
  int grants_checked;
  int error_grants;
  int frees_sent;
  int settings_used;
  int idle_cycles;
  int burst_left;
  bit gaps_on;
  bit hold_req;

  port_number_allocator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_port          (in_port),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_port (out_granted_port),
    .out_error        (out_error),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Generate the clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the grant for one accepted transaction and update the predictor
  function automatic void predict_allocation(input logic kind, input logic [PORT_W-1:0] port);
    int     cand;
    grant_t g;
    if (kind == KIND_FREE) begin
      frees_sent++;
      if (port_used[port]) begin
        port_used[port] = 1'b0;
        free_stack.push_back(port);
        last_freed = port;
        for (int i = 0; i < used_ports.size(); i++) begin
          if (used_ports[i] == port) begin
            used_ports.delete(i);
            break;
          end
        end
      end
      return;
    end
    if (free_stack.size() > 0) begin
      g.port = free_stack.pop_back();
      g.err  = 1'b0;
      port_used[g.port] = 1'b1;
      used_ports.push_back(g.port);
    end else begin
      // Step past the reserved numbers twice so an adjacent pair is skipped
      cand = fresh_cnt + 1;
      if (cand == res_a || cand == res_b) cand++;
      if (cand == res_a || cand == res_b) cand++;
      if (cand > TOP_PORT) begin
        g.port = '0;
        g.err  = 1'b1;
      end else begin
        fresh_cnt = cand;
        g.port = PORT_W'(cand);
        g.err  = 1'b0;
        port_used[g.port] = 1'b1;
        used_ports.push_back(g.port);
      end
    end
    expected_grants.push_back(g);
  endfunction

  // Offer one transaction, wait for acceptance, then maybe insert a gap
  task automatic send_item(input logic kind, input logic [PORT_W-1:0] port);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_port  <= port;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_allocation(kind, port);
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drain all outstanding grants and let trailing frees settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write both reserved numbers on back-to-back cycles
  task automatic write_reserved(input int a, input int b);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RESERVED_A;
    cfg_wdata <= CFG_DATA_W'(a);
    @(negedge clk);
    cfg_index <= REG_RESERVED_B;
    cfg_wdata <= CFG_DATA_W'(b);
    @(negedge clk);
    cfg_we <= 1'b0;
    res_a = a;
    res_b = b;
    settings_used++;
    @(negedge clk);
  endtask

  // Mixed gets and frees, frees mostly of ports currently in use
  task automatic run_random(input int count);
    int                r;
    logic [PORT_W-1:0] p;
    repeat (count) begin
      if ($urandom_range(0, 99) < 52) begin
        send_item(KIND_GET, PORT_W'($urandom_range(0, 65535)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70 && used_ports.size() > 0)
          p = used_ports[$urandom_range(0, used_ports.size() - 1)];
        else if (r < 80)
          p = last_freed;
        else if (r < 88)
          p = '0;
        else
          p = PORT_W'($urandom_range(0, 65535));
        send_item(KIND_FREE, p);
      end
    end
  endtask

  // Fresh numbers, adjacent reserved pair, LIFO reuse and ignored frees
  task automatic test_directed();
    write_reserved(1, 2);
    send_item(KIND_GET, '1);
    send_item(KIND_GET, '0);
    send_item(KIND_GET, 16'h5a5a);
    send_item(KIND_FREE, 16'd4);
    send_item(KIND_FREE, 16'd5);
    send_item(KIND_FREE, 16'd4);
    send_item(KIND_FREE, 16'd0);
    send_item(KIND_FREE, 16'hffff);
    send_item(KIND_FREE, 16'd100);
    send_item(KIND_FREE, 16'd1);
    send_item(KIND_GET, 16'ha5a5);
    send_item(KIND_GET, '0);
    send_item(KIND_GET, '0);
    send_item(KIND_FREE, 16'd3);
    send_item(KIND_FREE, 16'd6);
    send_item(KIND_FREE, 16'd7);
    send_item(KIND_GET, '0);
    send_item(KIND_GET, '0);
    send_item(KIND_GET, '0);
    send_item(KIND_GET, '0);
    wait_idle();
  endtask

  // Adjacent reserved pair just ahead of the fresh counter
  task automatic test_reserved_ahead();
    write_reserved(fresh_cnt + 3, fresh_cnt + 4);
    run_random(400);
    wait_idle();
  endtask

  // Reserved numbers at both ends of the range
  task automatic test_reserved_extremes();
    write_reserved(0, TOP_PORT);
    run_random(400);
    wait_idle();
  endtask

  // Random reserved numbers within reach of the counter, possibly equal
  task automatic test_random_reserved();
    int a;
    a = fresh_cnt + $urandom_range(1, 150);
    write_reserved(a, ($urandom_range(0, 3) == 0) ? a : fresh_cnt + $urandom_range(1, 150));
    run_random(450);
    wait_idle();
  endtask

  // Hold the result side for a long stretch while gets keep coming
  task automatic test_back_pressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_item(KIND_GET, PORT_W'($urandom_range(0, 65535)));
    gaps_on = 1'b1;
    wait_idle();
  endtask

  // Compare each accepted grant with the oldest expectation
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected grant: port %0d error %0b", out_granted_port, out_error);
        mismatch_count++;
      end else begin
        want = expected_grants.pop_front();
        grants_checked++;
        if (want.err) error_grants++;
        if (out_granted_port !== want.port) begin
          $error("granted_port: expected %0d, actual %0d", want.port, out_granted_port);
          mismatch_count++;
        end
        if (out_error !== want.err) begin
          $error("error: expected %0b, actual %0b", want.err, out_error);
          mismatch_count++;
        end
      end
    end
  end

  // Drive result-side stall: changing patterns plus one long hold on request
  initial begin
    int  hold_left;
    int  mode;
    int  mode_left;
    bit  toggle;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    toggle    = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      toggle = ~toggle;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= toggle;
        endcase
      end
    end
  end

  // Count cycles with no transaction on any port
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout after %0d idle cycles", IDLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Reset, run the tests in turn, drain and report
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_GET;
    in_port        = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_RESERVED_A;
    cfg_wdata      = '0;
    res_a          = int'(RESERVED_A_RST);
    res_b          = int'(RESERVED_B_RST);
    fresh_cnt      = 0;
    last_freed     = '0;
    mismatch_count = 0;
    grants_checked = 0;
    error_grants   = 0;
    frees_sent     = 0;
    settings_used  = 0;
    burst_left     = 0;
    gaps_on        = 1'b1;
    hold_req       = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_reserved_ahead();
    test_back_pressure();
    test_reserved_extremes();
    test_random_reserved();

    while (expected_grants.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d grants (%0d exhausted) and %0d frees across %0d reserved settings,",
             grants_checked, error_grants, frees_sent, settings_used);
    $display("including a long result hold and reserved numbers at both ends of the range.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
